// ===== rtl/spmq_pkg.sv =====
// Shared types, constants and index helpers for the sorted priority message queue.
`default_nettype none

package spmq_pkg;

  localparam int Depth    = 16;
  localparam int PrioBits = 8;
  localparam int PayloadW = 32;
  localparam int PrioInW  = 8;
  localparam int FillW    = 5;
  localparam int IdxW     = $clog2(Depth);
  localparam int CntW     = $clog2(Depth + 1);
  localparam int EntryW   = PrioBits + PayloadW;

  typedef logic [IdxW-1:0]     idx_t;
  typedef logic [CntW-1:0]     cnt_t;
  typedef logic [PrioBits-1:0] prio_t;
  typedef logic [PayloadW-1:0] payload_t;

  localparam logic [IdxW:0] DepthX  = (IdxW + 1)'(Depth);
  localparam cnt_t          CntFull = CntW'(Depth);
  localparam idx_t          IdxLast = IdxW'(Depth - 1);
  localparam prio_t         PrioMax = '1;

  typedef enum logic [1:0] {
    ReqOrdered = 2'd0,
    ReqHead    = 2'd1,
    ReqTail    = 2'd2,
    ReqGet     = 2'd3
  } req_e;

  typedef enum logic [1:0] {
    StDone  = 2'd0,
    StFull  = 2'd1,
    StEmpty = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    SqIdle,
    SqScan,
    SqPop,
    SqResp
  } seq_state_e;

  typedef struct packed {
    payload_t payload;
    status_e  status;
    cnt_t     fill;
  } result_t;

  typedef struct packed {
    logic    idle;
    logic    res_valid;
    result_t res;
  } seq_out_t;

  function automatic idx_t idx_add(idx_t a, idx_t b);
    logic [IdxW:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= DepthX) begin
      s = s - DepthX;
    end
    return s[IdxW-1:0];
  endfunction

  function automatic idx_t idx_inc(idx_t a);
    return idx_add(a, idx_t'(1));
  endfunction

  function automatic idx_t idx_dec(idx_t a);
    return (a == '0) ? IdxLast : idx_t'(a - idx_t'(1));
  endfunction

endpackage

`default_nettype wire

// ===== rtl/spmq_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module spmq_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

// ===== rtl/spmq_seq.sv =====
// Sequencer: circular store pointers, backward insertion walk and result build.
`default_nettype none

module spmq_seq (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         in_acc_i,
  input  wire logic [1:0]                   req_type_i,
  input  wire logic [spmq_pkg::PayloadW-1:0] payload_i,
  input  wire logic [spmq_pkg::PrioInW-1:0]  prio_i,
  input  wire logic                         out_free_i,
  output spmq_pkg::seq_out_t                seq_o
);

  spmq_pkg::seq_state_e state_q, state_d;
  spmq_pkg::idx_t       head_q, head_d;
  spmq_pkg::cnt_t       cnt_q, cnt_d;
  spmq_pkg::idx_t       wp_q, wp_d;
  spmq_pkg::prio_t      pr_q, pr_d;
  spmq_pkg::payload_t   pl_q, pl_d;
  spmq_pkg::result_t    res_q, res_d;

  logic                              we;
  spmq_pkg::idx_t                    waddr;
  spmq_pkg::idx_t                    raddr;
  logic [spmq_pkg::EntryW-1:0]       wdata;
  logic [spmq_pkg::EntryW-1:0]       rdata;
  spmq_pkg::prio_t                   rd_prio;
  spmq_pkg::idx_t                    tail;
  logic                              full;
  logic                              move;
  spmq_pkg::req_e                    req;

  spmq_ram #(
    .Width(spmq_pkg::EntryW),
    .Depth(spmq_pkg::Depth)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  assign req     = spmq_pkg::req_e'(req_type_i);
  assign rd_prio = rdata[spmq_pkg::EntryW-1 -: spmq_pkg::PrioBits];
  assign tail    = spmq_pkg::idx_add(head_q, cnt_q[spmq_pkg::IdxW-1:0]);
  assign full    = (cnt_q == spmq_pkg::CntFull);
  assign move    = (wp_q != head_q) && (rd_prio < pr_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= spmq_pkg::SqIdle;
      head_q  <= '0;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      head_q  <= head_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    wp_q  <= wp_d;
    pr_q  <= pr_d;
    pl_q  <= pl_d;
    res_q <= res_d;
  end

  always_comb begin
    state_d = state_q;
    head_d  = head_q;
    cnt_d   = cnt_q;
    wp_d    = wp_q;
    pr_d    = pr_q;
    pl_d    = pl_q;
    res_d   = res_q;
    we      = 1'b0;
    waddr   = wp_q;
    wdata   = {pr_q, pl_q};
    raddr   = spmq_pkg::idx_dec(wp_q);

    unique case (state_q)
      spmq_pkg::SqIdle: begin
        if (in_acc_i) begin
          res_d = '{payload: '0, status: spmq_pkg::StDone, fill: cnt_q};
          unique case (req)
            spmq_pkg::ReqGet: begin
              if (cnt_q == '0) begin
                res_d.status = spmq_pkg::StEmpty;
                state_d      = spmq_pkg::SqResp;
              end else begin
                raddr   = head_q;
                state_d = spmq_pkg::SqPop;
              end
            end
            spmq_pkg::ReqHead: begin
              if (full) begin
                res_d.status = spmq_pkg::StFull;
              end else begin
                we         = 1'b1;
                waddr      = spmq_pkg::idx_dec(head_q);
                wdata      = {spmq_pkg::PrioMax, payload_i};
                head_d     = spmq_pkg::idx_dec(head_q);
                cnt_d      = cnt_q + spmq_pkg::cnt_t'(1);
                res_d.fill = cnt_d;
              end
              state_d = spmq_pkg::SqResp;
            end
            spmq_pkg::ReqTail: begin
              if (full) begin
                res_d.status = spmq_pkg::StFull;
              end else begin
                we         = 1'b1;
                waddr      = tail;
                wdata      = {spmq_pkg::prio_t'(0), payload_i};
                cnt_d      = cnt_q + spmq_pkg::cnt_t'(1);
                res_d.fill = cnt_d;
              end
              state_d = spmq_pkg::SqResp;
            end
            spmq_pkg::ReqOrdered: begin
              if (full) begin
                res_d.status = spmq_pkg::StFull;
                state_d      = spmq_pkg::SqResp;
              end else begin
                wp_d    = tail;
                raddr   = spmq_pkg::idx_dec(tail);
                pr_d    = prio_i[spmq_pkg::PrioBits-1:0];
                pl_d    = payload_i;
                state_d = spmq_pkg::SqScan;
              end
            end
            default: ;
          endcase
        end
      end
      spmq_pkg::SqScan: begin
        we = 1'b1;
        if (move) begin
          // shift the lower-priority entry back one place, look one further forward
          wdata = rdata;
          wp_d  = spmq_pkg::idx_dec(wp_q);
          raddr = spmq_pkg::idx_dec(spmq_pkg::idx_dec(wp_q));
        end else begin
          cnt_d      = cnt_q + spmq_pkg::cnt_t'(1);
          res_d.fill = cnt_d;
          state_d    = spmq_pkg::SqResp;
        end
      end
      spmq_pkg::SqPop: begin
        res_d.payload = rdata[spmq_pkg::PayloadW-1:0];
        head_d        = spmq_pkg::idx_inc(head_q);
        cnt_d         = cnt_q - spmq_pkg::cnt_t'(1);
        res_d.fill    = cnt_d;
        state_d       = spmq_pkg::SqResp;
      end
      spmq_pkg::SqResp: begin
        if (out_free_i) begin
          state_d = spmq_pkg::SqIdle;
        end
      end
      default: state_d = spmq_pkg::SqIdle;
    endcase
  end

  assign seq_o.idle      = (state_q == spmq_pkg::SqIdle);
  assign seq_o.res_valid = (state_q == spmq_pkg::SqResp);
  assign seq_o.res       = res_q;

endmodule

`default_nettype wire

// ===== rtl/sorted_priority_message_queue.sv =====
// Sorted priority message queue: top level with input handshake and output register.
//
// Usage: one request transaction on the input channel (req_type_i, payload_i,
// prio_i) yields exactly one result transaction on the output channel
// (out_payload_o, status_o, fill_o). Requests are ordered put, put at head,
// put at tail and get; up to Depth entries are held in a circular store in
// a single RAM, front entry served first.
// Timing: in_stall_o is high while a request is being worked on, so one
// request is in flight at a time. Head put, tail put, full and empty
// answers enter the result register on acceptance and go on to the output
// register; a get first reads the front entry in a pop state. An ordered
// put walks backward from the tail, one RAM entry per cycle through a
// single priority comparator, moving up to Depth - 1 lower-priority entries back.
// The next request is taken in the cycle after the output register loads.
// Reset empties the store at once; no clearing pass is needed.
// When out_stall_i holds the output register, the finished result waits in
// the sequencer and the next request is taken only after it moves out.
`default_nettype none

module sorted_priority_message_queue (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire logic [1:0]                    req_type_i,
  input  wire logic [spmq_pkg::PayloadW-1:0] payload_i,
  input  wire logic [spmq_pkg::PrioInW-1:0]  prio_i,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic [spmq_pkg::PayloadW-1:0]      out_payload_o,
  output logic [1:0]                         status_o,
  output logic [spmq_pkg::FillW-1:0]         fill_o
);

  spmq_pkg::seq_out_t seq;
  spmq_pkg::result_t  out_q;
  logic               out_valid_q, out_valid_d;
  logic               out_free;
  logic               in_acc;
  logic               load;

  assign in_stall_o = !seq.idle;
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;
  assign load       = seq.res_valid && out_free;

  spmq_seq u_seq (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_acc_i  (in_acc),
    .req_type_i(req_type_i),
    .payload_i (payload_i),
    .prio_i    (prio_i),
    .out_free_i(out_free),
    .seq_o     (seq)
  );

  always_comb begin
    out_valid_d = out_valid_q;
    if (load) begin
      out_valid_d = 1'b1;
    end else if (out_free) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_q <= seq.res;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign out_payload_o = out_q.payload;
  assign status_o      = out_q.status;
  assign fill_o        = spmq_pkg::FillW'(out_q.fill);

endmodule

`default_nettype wire

// ===== rtl/spmq_chk.sv =====
// Port-level checker for the sorted priority message queue, bound to the top level.
`default_nettype none

module spmq_chk (
  input wire logic                          clk_i,
  input wire logic                          rst_ni,
  input wire logic                          in_valid_i,
  input wire logic                          in_stall_o,
  input wire logic                          out_valid_o,
  input wire logic                          out_stall_i,
  input wire logic [spmq_pkg::PayloadW-1:0] out_payload_o,
  input wire logic [1:0]                    status_o,
  input wire logic [spmq_pkg::FillW-1:0]    fill_o
);

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("input taken while a transaction is in flight");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(out_payload_o)
      && $stable(status_o) && $stable(fill_o)))
    else $error("stalled result changed");

  a_full_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o == spmq_pkg::StFull)
      |-> (fill_o == spmq_pkg::FillW'(spmq_pkg::Depth) && out_payload_o == '0))
    else $error("full status without a full store");

  a_empty_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o == spmq_pkg::StEmpty)
      |-> (fill_o == '0 && out_payload_o == '0))
    else $error("empty status with entries held");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (status_o == spmq_pkg::StDone || status_o == spmq_pkg::StFull
      || status_o == spmq_pkg::StEmpty))
    else $error("undefined status code");

endmodule

bind sorted_priority_message_queue spmq_chk u_spmq_chk (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_valid_i),
  .in_stall_o   (in_stall_o),
  .out_valid_o  (out_valid_o),
  .out_stall_i  (out_stall_i),
  .out_payload_o(out_payload_o),
  .status_o     (status_o),
  .fill_o       (fill_o)
);

`default_nettype wire
